// ===== src/nps_pkg.sv =====
// nps_pkg: types, codes and widths shared by the nearest point search block
// used by nps_cell and nearest_point_search; no other dependencies
package nps_pkg;

    localparam int COORD_BITS    = 24;
    localparam int DIST_W        = 2 * COORD_BITS + 1;
    localparam int SLOT_W        = 6;
    localparam int GROUP_W       = 16;
    localparam int LINK_W        = 10;
    localparam int TABLE_DEPTH_D = 64;
    localparam int CELL_LAT      = 3;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;

    localparam logic [1:0] ST_CLEARED = 2'd0;
    localparam logic [1:0] ST_WRITTEN = 2'd1;
    localparam logic [1:0] ST_FOUND   = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]                    opcode;
        logic [SLOT_W-1:0]             slot;
        logic [GROUP_W-1:0]            group_index;
        logic [LINK_W-1:0]             link_index;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [GROUP_W-1:0] found_group;
        logic [LINK_W-1:0]  found_link;
    } rsp_t;

    typedef struct packed {
        logic                          clr;
        logic                          wr;
        logic [SLOT_W-1:0]             slot;
        logic [GROUP_W-1:0]            group;
        logic [LINK_W-1:0]             link;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
    } cell_cmd_t;

    typedef struct packed {
        logic               go;
        logic               have;
        logic [DIST_W-1:0]  min_dist;
        logic [GROUP_W-1:0] group;
        logic [LINK_W-1:0]  link;
    } scan_tok_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_LAUNCH,
        S_SCAN,
        S_PUSH
    } state_t;

endpackage

// ===== src/nps_cell.sv =====
// nps_cell: one table slot with its own distance pipeline and a stage of the
// running-minimum chain; depends on nps_pkg
module nps_cell
    import nps_pkg::*;
#(
    parameter int CELL_ID = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_cmd_t                     cmd,
    input  logic signed [COORD_BITS-1:0]  query_x,
    input  logic signed [COORD_BITS-1:0]  query_y,
    input  scan_tok_t                     tok_in,
    output scan_tok_t                     tok_out
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [COORD_BITS-1:0]  px_reg;
    logic signed [COORD_BITS-1:0]  py_reg;
    logic [GROUP_W-1:0]            group_reg;
    logic [LINK_W-1:0]             link_reg;
    logic [COORD_BITS-1:0]         adx_reg;
    logic [COORD_BITS-1:0]         ady_reg;
    logic [COORD_BITS-1:0]         adx_next;
    logic [COORD_BITS-1:0]         ady_next;
    logic [2*COORD_BITS-1:0]       sqx_reg;
    logic [2*COORD_BITS-1:0]       sqy_reg;
    logic [DIST_W-1:0]             dist_reg;
    logic signed [COORD_BITS:0]    dx;
    logic signed [COORD_BITS:0]    dy;
    logic signed [COORD_BITS:0]    ndx;
    logic signed [COORD_BITS:0]    ndy;
    logic                          hit;
    scan_tok_t                     tok_reg;
    scan_tok_t                     tok_next;

    assign hit = cmd.wr && (32'(cmd.slot) == 32'(CELL_ID));

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clr)
        begin
            valid_next = 1'b0;
        end
        else if (hit)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            px_reg    <= cmd.x;
            py_reg    <= cmd.y;
            group_reg <= cmd.group;
            link_reg  <= cmd.link;
        end
    end

    // distance pipeline: abs difference, squares, sum
    always_comb
    begin
        dx       = {px_reg[COORD_BITS-1], px_reg} - {query_x[COORD_BITS-1], query_x};
        dy       = {py_reg[COORD_BITS-1], py_reg} - {query_y[COORD_BITS-1], query_y};
        ndx      = -dx;
        ndy      = -dy;
        adx_next = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady_next = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        sqx_reg  <= {{COORD_BITS{1'b0}}, adx_reg} * {{COORD_BITS{1'b0}}, adx_reg};
        sqy_reg  <= {{COORD_BITS{1'b0}}, ady_reg} * {{COORD_BITS{1'b0}}, ady_reg};
        dist_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    // first strict minimum wins, so a later equal distance is passed over
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.go && valid_reg && (!tok_in.have || (dist_reg < tok_in.min_dist)))
        begin
            tok_next.have     = 1'b1;
            tok_next.min_dist = dist_reg;
            tok_next.group    = group_reg;
            tok_next.link     = link_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/nearest_point_search.sv =====
// nearest_point_search: top level, control sequencer and the row of slot cells
// depends on nps_pkg and nps_cell
//
// usage
//   req channel (req_valid/req_ready/req) takes one request at a time:
//   clear table, write a slot, or query the nearest stored point.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one response per
//   request, in request order.
//   clear and write take effect at acceptance; their response is registered
//   in res_reg and then moved to the output register in S_PUSH. a query
//   goes through the per-slot distance pipeline (abs difference, squares,
//   sum) in S_FILL, the launch state, the running minimum moving one cell
//   per cycle down the row of TABLE_DEPTH cells, then S_PUSH into the
//   output register. a new request is taken only after the last one has
//   passed S_PUSH.
//   a finished response sits in the output register; a new request is taken
//   while it waits, and the next response waits until rsp_ready frees it.
//   reset empties the table (all valid bits cleared) and drops any response.
module nearest_point_search
    import nps_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_D
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int FILL_W = $clog2(CELL_LAT);

    state_t                        state_reg;
    state_t                        state_next;
    logic [FILL_W-1:0]             fill_cnt_reg;
    logic [FILL_W-1:0]             fill_cnt_next;
    logic signed [COORD_BITS-1:0]  qx_reg;
    logic signed [COORD_BITS-1:0]  qy_reg;
    rsp_t                          res_reg;
    rsp_t                          res_next;
    rsp_t                          rsp_reg;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic                          accept;
    logic                          is_query;
    logic                          launch;
    logic                          push;
    cell_cmd_t                     cmd;
    scan_tok_t                     tok [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]        go_vec;

    assign accept   = req_valid && req_ready;
    assign is_query = req.opcode[1];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = is_query ? S_FILL : S_PUSH;
                end
            end
            S_FILL:
            begin
                if (fill_cnt_reg == FILL_W'(CELL_LAT - 1))
                begin
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (tok[TABLE_DEPTH].go)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_ready = 1'b0;
        launch    = 1'b0;
        push      = 1'b0;
        unique case (state_reg)
            S_IDLE:   req_ready = 1'b1;
            S_FILL:   req_ready = 1'b0;
            S_LAUNCH: launch    = 1'b1;
            S_SCAN:   req_ready = 1'b0;
            S_PUSH:   push      = !rsp_valid_reg || rsp_ready;
            default:  req_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd.clr   = accept && (req.opcode == OP_CLEAR);
        cmd.wr    = accept && (req.opcode == OP_WRITE);
        cmd.slot  = req.slot;
        cmd.group = req.group_index;
        cmd.link  = req.link_index;
        cmd.x     = req.pos_x;
        cmd.y     = req.pos_y;
    end

    always_comb
    begin
        fill_cnt_next = '0;
        if (state_reg == S_FILL)
        begin
            fill_cnt_next = fill_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (accept && !is_query)
        begin
            res_next.status      = (req.opcode == OP_WRITE) ? ST_WRITTEN : ST_CLEARED;
            res_next.found_group = '0;
            res_next.found_link  = '0;
        end
        else if ((state_reg == S_SCAN) && tok[TABLE_DEPTH].go)
        begin
            if (tok[TABLE_DEPTH].have)
            begin
                res_next.status      = ST_FOUND;
                res_next.found_group = tok[TABLE_DEPTH].group;
                res_next.found_link  = tok[TABLE_DEPTH].link;
            end
            else
            begin
                res_next.status      = ST_EMPTY;
                res_next.found_group = '0;
                res_next.found_link  = '0;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (push)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept && is_query)
        begin
            qx_reg <= req.pos_x;
            qy_reg <= req.pos_y;
        end
        if (push)
        begin
            rsp_reg <= res_reg;
        end
    end

    // head of the chain: an empty running minimum
    always_comb
    begin
        tok[0]      = '0;
        tok[0].go   = launch;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        nps_cell #(
            .CELL_ID (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .query_x (qx_reg),
            .query_y (qy_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
        assign go_vec[i] = tok[i+1].go;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(go_vec))
        else $error("more than one scan token in the cell row");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok[TABLE_DEPTH].go |-> (state_reg == S_SCAN))
        else $error("scan token left the row outside a scan");

    a_query_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_query) |=> (state_reg == S_FILL))
        else $error("accepted query did not start the distance pipeline");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_FOUND))
        |-> ((rsp.found_group == '0) && (rsp.found_link == '0)))
        else $error("response without a match carries nonzero indices");

endmodule
